// ----- design/sncv_pkg.sv -----
package sncv_pkg;

   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned BASE_LEN = 8;
   localparam int unsigned EXT_LEN  = 3;

   localparam logic [3:0] FULL_LEN_C = 4'd11;
   localparam logic [3:0] BASE_LEN_C = 4'd8;
   localparam logic [1:0] EXT_LEN_C  = 2'd3;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   typedef logic [CHAR_W-1:0]                char_type;
   typedef logic [BASE_LEN-1:0][CHAR_W-1:0] base_type;
   typedef logic [EXT_LEN-1:0][CHAR_W-1:0]  ext_type;

   typedef struct packed {
      base_type base_chars;
      ext_type  ext_chars;
   } result_type;

   localparam base_type BASE_BLANK = {BASE_LEN{CH_SPACE}};
   localparam ext_type  EXT_BLANK  = {EXT_LEN{CH_SPACE}};

   function automatic char_type upcase(input char_type c);
      if (c >= 8'h61 && c <= 8'h7A) begin
         return c - 8'h20;
      end
      return c;
   endfunction

   function automatic logic is_ws(input char_type c);
      return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

endpackage

// ----- design/sncv_core.sv -----
module sncv_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  sncv_pkg::char_type    step_ch,
   input  logic                  step_dir,
   output sncv_pkg::result_type  name_out
);
   import sncv_pkg::*;

   typedef enum logic [2:0] {
      PH_FIRST  = 3'd0,
      PH_SKIP   = 3'd1,
      PH_DOT1   = 3'd2,
      PH_IGNORE = 3'd3,
      PH_BASE   = 3'd4,
      PH_EXT    = 3'd5
   } phase_type;

   phase_type  phase_ff, phase_in;
   base_type   base_ff, base_in;
   ext_type    ext_ff, ext_in;
   logic [3:0] base_count_ff, base_count_in;
   logic [1:0] ext_count_ff, ext_count_in;
   logic       dir_mode_ff, dir_mode_in;

   always_comb begin
      phase_type ph;
      char_type  up;
      logic      dir;
      logic [3:0] limit;

      phase_in      = phase_ff;
      base_in       = base_ff;
      ext_in        = ext_ff;
      base_count_in = base_count_ff;
      ext_count_in  = ext_count_ff;
      dir_mode_in   = dir_mode_ff;
      up            = upcase(step_ch);
      ph            = phase_ff;
      dir           = dir_mode_ff;
      limit         = BASE_LEN_C;

      if (step_en) begin
         if (phase_ff == PH_FIRST) begin
            dir = step_dir;
            ph  = PH_SKIP;
         end
         dir_mode_in = dir;
         phase_in    = ph;
         limit       = dir ? FULL_LEN_C : BASE_LEN_C;

         if (step_ch == CH_NUL) begin
            phase_in      = PH_FIRST;
            base_in       = BASE_BLANK;
            ext_in        = EXT_BLANK;
            base_count_in = '0;
            ext_count_in  = '0;
            dir_mode_in   = 1'b0;
         end else begin
            case (ph)
               PH_SKIP: begin
                  if (!is_ws(step_ch)) begin
                     if (step_ch == CH_DOT) begin
                        base_in[0] = CH_DOT;
                        phase_in   = PH_DOT1;
                     end else begin
                        base_in[0]    = up;
                        base_count_in = 4'd1;
                        phase_in      = PH_BASE;
                     end
                  end
               end
               PH_DOT1: begin
                  if (step_ch == CH_DOT) begin
                     base_in[1] = CH_DOT;
                  end
                  phase_in = PH_IGNORE;
               end
               PH_BASE: begin
                  if (step_ch == CH_DOT) begin
                     ext_in   = EXT_BLANK;
                     phase_in = PH_EXT;
                  end else begin
                     if (base_count_ff < limit) begin
                        if (base_count_ff < BASE_LEN_C) begin
                           base_in[base_count_ff[2:0]] = up;
                        end else begin
                           ext_in[base_count_ff[1:0]] = up;
                        end
                     end
                     if (base_count_ff < FULL_LEN_C) begin
                        base_count_in = base_count_ff + 4'd1;
                     end
                  end
               end
               PH_EXT: begin
                  if (ext_count_ff < EXT_LEN_C) begin
                     ext_in[ext_count_ff] = up;
                     ext_count_in         = ext_count_ff + 2'd1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FIRST;
         base_ff       <= BASE_BLANK;
         ext_ff        <= EXT_BLANK;
         base_count_ff <= '0;
         ext_count_ff  <= '0;
         dir_mode_ff   <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         base_ff       <= base_in;
         ext_ff        <= ext_in;
         base_count_ff <= base_count_in;
         ext_count_ff  <= ext_count_in;
         dir_mode_ff   <= dir_mode_in;
      end
   end

   assign name_out.base_chars = base_ff;
   assign name_out.ext_chars  = ext_ff;

endmodule

// ----- design/short_name_converter.sv -----
// Channel  Direction  Handshake           Payload
// req_     in         req_valid/req_stall req_ch[7:0], req_is_dir
// rsp_     out        rsp_valid/rsp_stall rsp_base_chars[63:0], rsp_ext_chars[23:0]
//
// One byte is taken every cycle unless req_stall holds the input; a result becomes valid once
// its zero byte leaves the input register while the result register is free.
// The rate is set by the name state update behind the input register.
// Reset clears the name state to all spaces and empties both registers.
// A zero byte waits in the input register only while a result is stalled.
module short_name_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_is_dir,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_base_chars,
   output logic [23:0] rsp_ext_chars
);
   import sncv_pkg::*;

   logic       in_valid_ff;
   char_type   in_ch_ff;
   logic       in_dir_ff;
   logic       out_free;
   logic       advance;
   logic       release_name;
   result_type name_cur;
   result_type rsp_data_ff;
   logic       rsp_valid_ff;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign advance      = in_valid_ff && ((in_ch_ff != CH_NUL) || out_free);
   assign release_name = advance && (in_ch_ff == CH_NUL);
   assign req_stall    = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ch_ff  <= req_ch;
         in_dir_ff <= req_is_dir;
      end
   end

   sncv_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .step_ch  (in_ch_ff),
      .step_dir (in_dir_ff),
      .name_out (name_cur)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (release_name) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (release_name) begin
         rsp_data_ff <= name_cur;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_base_chars = rsp_data_ff.base_chars;
   assign rsp_ext_chars  = rsp_data_ff.ext_chars;

   // A name is released only from a terminating zero byte.
   a_release_from_nul: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_ch_ff == CH_NUL))
      else $error("result raised without a terminating byte");

   // The input side stalls only behind a stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && in_ch_ff == CH_NUL))
      else $error("input stalled without a stalled result");

   // A released name always shows up as a valid result in the next cycle.
   a_release_shows: assert property (@(posedge clock) disable iff (reset)
      release_name |=> rsp_valid_ff)
      else $error("released name not presented");

endmodule
